@@ rtl/core/dkpq_pkg.sv @@
// dkpq_pkg: shared types, operation codes and key compare for the process queue
// used by dkpq_cell and dual_key_process_queue; no dependencies
`timescale 1ns / 1ps
package dkpq_pkg;

    // operation codes
    localparam logic [2:0] F_ADD   = 3'd0;
    localparam logic [2:0] F_EXEC  = 3'd1;
    localparam logic [2:0] F_NEXT  = 3'd2;
    localparam logic [2:0] F_CHGP  = 3'd3;
    localparam logic [2:0] F_CHGT  = 3'd4;
    localparam logic [2:0] F_PRINT = 3'd5;

    // one input beat
    typedef struct packed {
        logic [2:0]  func;
        logic        by_time;
        logic [6:0]  priority_req;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [6:0]  new_priority;
        logic [4:0]  new_hour;
        logic [5:0]  new_minute;
        logic [5:0]  new_second;
        logic [31:0] tag;
    } t_in;

    // one result beat
    typedef struct packed {
        logic [6:0]  out_priority;
        logic [4:0]  out_hour;
        logic [5:0]  out_minute;
        logic [5:0]  out_second;
        logic [31:0] out_tag;
        logic        last;
    } t_out;

    // one stored entry
    typedef struct packed {
        logic [6:0]  pri;
        logic [4:0]  hh;
        logic [5:0]  mm;
        logic [5:0]  ss;
        logic [31:0] tag;
    } t_entry;

    // true when a strictly goes before b under the chosen key
    function automatic logic f_precedes(input t_entry a, input t_entry b,
                                        input logic by_time);
        logic res;
        if (by_time) begin
            res = {a.hh, a.mm, a.ss} < {b.hh, b.mm, b.ss};
        end else begin
            res = a.pri > b.pri;
        end
        return res;
    endfunction

endpackage

@@ rtl/core/dkpq_cell.sv @@
// dkpq_cell: one storage cell of the entry ring, takes its right neighbor on shift
// depends on dkpq_pkg
`timescale 1ns / 1ps
module dkpq_cell (
    input  logic             i_clk,
    input  logic             i_shift,
    input  dkpq_pkg::t_entry i_d,
    output dkpq_pkg::t_entry o_q
);
    import dkpq_pkg::*;

    t_entry r_q;

    // hold or take neighbor
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;
endmodule

@@ rtl/core/dual_key_process_queue.sv @@
// dual_key_process_queue: entry table as a ring of cells with scan and rewrite passes
// depends on dkpq_pkg and dkpq_cell
//
//   channel  | signals                  | handshake
//   command  | start, i_cmd, busy       | beat taken when start & !busy
//   result   | o_valid, o_result        | one-cycle strobe, no back pressure
//
// every pass rotates the whole ring once
// each command is accepted in the idle state, then runs its passes
// add and change take one pass, next one pass, exec two passes
// print takes two passes per stored entry
// ignored commands leave the sequencer idle; reset clears the count, cell contents are left
`timescale 1ns / 1ps
module dual_key_process_queue #(
    parameter int CAPACITY = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  dkpq_pkg::t_in  i_cmd,
    output logic           busy,
    output logic           o_valid,
    output dkpq_pkg::t_out o_result
);
    import dkpq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_MOVE} t_state;

    t_state          r_state;
    t_in             r_cmd;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_step;
    logic [CW-1:0]   r_p;
    logic [CW-1:0]   r_bidx;
    t_entry          r_best;
    t_entry          r_prev;
    logic            r_done;
    logic            r_valid;
    t_out            r_result;

    t_entry          w_q [CAPACITY];
    t_entry          w_head;
    t_entry          w_nxt;
    t_entry          n_tail;
    t_entry          w_new;
    t_entry          w_best;
    logic            w_shift;
    logic            w_end;
    logic            w_cand;
    logic            w_take;
    logic            w_chg;

    // ring of cells
    assign w_shift = (r_state != S_IDLE);
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == CAPACITY - 1) begin : g_tail
            dkpq_cell u_cell (.i_clk(i_clk), .i_shift(w_shift), .i_d(n_tail), .o_q(w_q[g]));
        end else begin : g_body
            dkpq_cell u_cell (.i_clk(i_clk), .i_shift(w_shift), .i_d(w_q[g+1]),
                              .o_q(w_q[g]));
        end
    end

    assign w_head = w_q[0];
    assign w_nxt  = w_q[1];
    assign w_end  = (r_step == CW'(CAPACITY - 1));
    assign w_cand = (r_step >= r_p) && (r_step < r_count);

    // running best including the entry now at the head
    assign w_take = w_cand && ((r_step == r_p)
                    || f_precedes(w_head, r_best, r_cmd.by_time));
    assign w_best = w_take ? w_head : r_best;

    // new entry for add
    assign w_new = '{pri: r_cmd.priority_req, hh: r_cmd.hour, mm: r_cmd.minute,
                     ss: r_cmd.second, tag: r_cmd.tag};

    // first-match test for change
    always_comb begin
        w_chg = !r_done && (r_step < r_count);
        if (r_cmd.func == F_CHGP) begin
            w_chg = w_chg && (w_head.pri == r_cmd.priority_req);
        end else begin
            w_chg = w_chg && (w_head.hh == r_cmd.hour) && (w_head.mm == r_cmd.minute)
                    && (w_head.ss == r_cmd.second);
        end
    end

    // value written at the tail of the ring
    always_comb begin
        n_tail = w_head;
        if (r_state == S_MOVE) begin
            case (r_cmd.func)
                F_ADD: begin
                    if (r_step == r_count) begin
                        n_tail = w_new;
                    end
                end
                F_EXEC: begin
                    if (r_step >= r_bidx) begin
                        n_tail = w_nxt;
                    end
                end
                F_PRINT: begin
                    if (r_step == r_p) begin
                        n_tail = r_best;
                    end else if (r_step > r_p && r_step <= r_bidx) begin
                        n_tail = r_prev;
                    end
                end
                F_CHGP: begin
                    if (w_chg) begin
                        n_tail.pri = r_cmd.new_priority;
                    end
                end
                F_CHGT: begin
                    if (w_chg) begin
                        n_tail.hh = r_cmd.new_hour;
                        n_tail.mm = r_cmd.new_minute;
                        n_tail.ss = r_cmd.new_second;
                    end
                end
                default: n_tail = w_head;
            endcase
        end
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_valid <= (r_state == S_SCAN) && w_end
                       && (r_cmd.func == F_NEXT || r_cmd.func == F_PRINT);
            r_prev  <= w_head;
            case (r_state)
                S_IDLE: begin
                    r_step <= '0;
                    r_p    <= '0;
                    r_done <= 1'b0;
                    if (start) begin
                        r_cmd <= i_cmd;
                        case (i_cmd.func)
                            F_ADD: begin
                                if (r_count < CW'(CAPACITY)) begin
                                    r_state <= S_MOVE;
                                end
                            end
                            F_EXEC, F_NEXT, F_PRINT: begin
                                if (r_count != '0) begin
                                    r_state <= S_SCAN;
                                end
                            end
                            F_CHGP, F_CHGT: r_state <= S_MOVE;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SCAN: begin
                    r_step <= w_end ? '0 : r_step + CW'(1);
                    if (w_take) begin
                        r_best <= w_head;
                        r_bidx <= r_step;
                    end
                    if (w_end) begin
                        case (r_cmd.func)
                            F_NEXT: begin
                                r_state <= S_IDLE;
                                r_result <= '{out_priority: w_best.pri, out_hour: w_best.hh,
                                              out_minute: w_best.mm, out_second: w_best.ss,
                                              out_tag: w_best.tag, last: 1'b1};
                            end
                            F_PRINT: begin
                                r_state <= S_MOVE;
                                r_result <= '{out_priority: w_best.pri, out_hour: w_best.hh,
                                              out_minute: w_best.mm, out_second: w_best.ss,
                                              out_tag: w_best.tag,
                                              last: ((r_p + CW'(1)) == r_count)};
                            end
                            default: r_state <= S_MOVE;
                        endcase
                    end
                end
                S_MOVE: begin
                    r_step <= w_end ? '0 : r_step + CW'(1);
                    if (w_chg && (r_cmd.func == F_CHGP || r_cmd.func == F_CHGT)) begin
                        r_done <= 1'b1;
                    end
                    if (w_end) begin
                        case (r_cmd.func)
                            F_ADD: begin
                                r_count <= r_count + CW'(1);
                                r_state <= S_IDLE;
                            end
                            F_EXEC: begin
                                r_count <= r_count - CW'(1);
                                r_state <= S_IDLE;
                            end
                            F_PRINT: begin
                                r_p <= r_p + CW'(1);
                                r_state <= ((r_p + CW'(1)) != r_count) ? S_SCAN : S_IDLE;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;
endmodule

@@ verif/dual_key_process_queue_tb.sv @@
// dual_key_process_queue_tb: self-checking bench for the process queue table
// depends on dkpq_pkg and dual_key_process_queue; predicts results from a local table
`timescale 1ns / 1ps
module dual_key_process_queue_tb;
    import dkpq_pkg::*;

    localparam int CAP = 32;
    localparam longint LIMIT = 3000000;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start = 1'b0;
    t_in    i_cmd = '0;
    logic   busy;
    logic   o_valid;
    t_out   o_result;

    // sender idle percentage, changed per phase
    int     send_idle_pct = 0;
    int     errors = 0;
    longint cycles = 0;

    // local copy of the table and the results it predicts
    t_entry table_q[$];
    t_out   pending_results[$];

    dual_key_process_queue #(.CAPACITY(CAP)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_cmd(i_cmd),
        .busy(busy), .o_valid(o_valid), .o_result(o_result)
    );

    always #4 i_clk = ~i_clk;

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic goes_first(t_entry a, t_entry b, logic by_time);
        if (by_time)
            return {a.hh, a.mm, a.ss} < {b.hh, b.mm, b.ss};
        return a.pri > b.pri;
    endfunction

    function automatic int pick_index(logic by_time);
        int best;
        best = 0;
        for (int i = 1; i < table_q.size(); i++)
            if (goes_first(table_q[i], table_q[best], by_time)) best = i;
        return best;
    endfunction

    function automatic t_out as_result(t_entry e, logic last);
        t_out r;
        r.out_priority = e.pri;
        r.out_hour = e.hh;
        r.out_minute = e.mm;
        r.out_second = e.ss;
        r.out_tag = e.tag;
        r.last = last;
        return r;
    endfunction

    // advance the local table by one command and queue its results
    task automatic predict_queue(t_in c);
        t_entry e, cur;
        int     k, j;
        case (c.func)
            F_ADD: begin
                if (table_q.size() < CAP) begin
                    e.pri = c.priority_req;
                    e.hh = c.hour;
                    e.mm = c.minute;
                    e.ss = c.second;
                    e.tag = c.tag;
                    table_q.push_back(e);
                end
            end
            F_EXEC: begin
                if (table_q.size() > 0) table_q.delete(pick_index(c.by_time));
            end
            F_NEXT: begin
                if (table_q.size() > 0)
                    pending_results.push_back(as_result(table_q[pick_index(c.by_time)], 1'b1));
            end
            F_CHGP: begin
                for (k = 0; k < table_q.size(); k++)
                    if (table_q[k].pri == c.priority_req) begin
                        table_q[k].pri = c.new_priority;
                        break;
                    end
            end
            F_CHGT: begin
                for (k = 0; k < table_q.size(); k++)
                    if ({table_q[k].hh, table_q[k].mm, table_q[k].ss} ==
                        {c.hour, c.minute, c.second}) begin
                        table_q[k].hh = c.new_hour;
                        table_q[k].mm = c.new_minute;
                        table_q[k].ss = c.new_second;
                        break;
                    end
            end
            F_PRINT: begin
                // stable insertion sort, then report every entry
                for (k = 1; k < table_q.size(); k++) begin
                    cur = table_q[k];
                    j = k;
                    while (j > 0 && goes_first(cur, table_q[j-1], c.by_time)) begin
                        table_q[j] = table_q[j-1];
                        j--;
                    end
                    table_q[j] = cur;
                end
                for (k = 0; k < table_q.size(); k++)
                    pending_results.push_back(as_result(table_q[k], k == table_q.size() - 1));
            end
            default: ;
        endcase
    endtask

    // check each result beat against the oldest prediction
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, o_result);
            end else begin
                exp_r = pending_results.pop_front();
                if (o_result !== exp_r) begin
                    errors++;
                    $display("%0t: result mismatch, expected %h, actual %h",
                             $time, exp_r, o_result);
                end
            end
        end
    end

    // send one command beat after dropping start and idling at random
    task automatic send_cmd(t_in c);
        @(posedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_queue(c);
        start <= 1'b0;
    endtask

    function automatic t_in make_cmd(logic [2:0] f, logic bt, logic [6:0] p,
                                     logic [4:0] h, logic [5:0] m, logic [5:0] s);
        t_in c;
        c = '0;
        c.func = f;
        c.by_time = bt;
        c.priority_req = p;
        c.hour = h;
        c.minute = m;
        c.second = s;
        c.tag = $urandom;
        return c;
    endfunction

    function automatic t_in rand_cmd();
        t_in c;
        int  pick;
        c = '0;
        c.by_time = 1'($urandom_range(1));
        // narrow value pools so ties and change matches are common
        c.priority_req = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(6) * 16);
        c.hour = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(2) * 11);
        c.minute = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(1) * 59);
        c.second = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(1) * 42);
        c.new_priority = 7'($urandom);
        c.new_hour = 5'($urandom);
        c.new_minute = 6'($urandom);
        c.new_second = 6'($urandom);
        c.tag = $urandom;
        pick = $urandom_range(99);
        if (pick < 38) c.func = F_ADD;
        else if (pick < 55) c.func = F_EXEC;
        else if (pick < 70) c.func = F_NEXT;
        else if (pick < 80) c.func = F_CHGP;
        else if (pick < 90) c.func = F_CHGT;
        else if (pick < 97) c.func = F_PRINT;
        else c.func = 3'($urandom_range(6, 7));
        return c;
    endfunction

    // wait until every predicted result has come, then let the last pass drain
    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4 * CAP) @(posedge i_clk);
    endtask

    // empty table, extremes, fill past capacity, ties and special functions
    task automatic test_directed();
        t_in c;
        send_cmd(make_cmd(F_EXEC, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(F_NEXT, 1, 0, 0, 0, 0));
        send_cmd(make_cmd(F_PRINT, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(3'd6, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(3'd7, 1, 0, 0, 0, 0));
        send_cmd(make_cmd(F_ADD, 0, 7'h7f, 5'h1f, 6'h3f, 6'h3f));
        send_cmd(make_cmd(F_ADD, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(F_ADD, 0, 7'h7f, 0, 0, 0));
        send_cmd(make_cmd(F_NEXT, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(F_NEXT, 1, 0, 0, 0, 0));
        c = make_cmd(F_CHGP, 0, 7'h55, 0, 0, 0);
        send_cmd(c);
        c = make_cmd(F_CHGP, 0, 7'h7f, 0, 0, 0);
        c.new_priority = 7'd99;
        send_cmd(c);
        c = make_cmd(F_CHGT, 0, 0, 5'd3, 0, 0);
        send_cmd(c);
        c = make_cmd(F_CHGT, 0, 0, 5'h1f, 6'h3f, 6'h3f);
        c.new_hour = 5'd23;
        c.new_minute = 6'd59;
        c.new_second = 6'd59;
        send_cmd(c);
        send_cmd(make_cmd(F_PRINT, 1, 0, 0, 0, 0));
        send_cmd(make_cmd(F_EXEC, 1, 0, 0, 0, 0));
        send_cmd(make_cmd(F_PRINT, 0, 0, 0, 0, 0));
        // fill to capacity; the last two adds must be dropped
        for (int i = 0; i < CAP; i++)
            send_cmd(make_cmd(F_ADD, 0, 7'(i % 3), 5'(i % 2), 0, 0));
        send_cmd(make_cmd(F_NEXT, 1, 0, 0, 0, 0));
        send_cmd(make_cmd(F_PRINT, 0, 0, 0, 0, 0));
        while (table_q.size() > 0)
            send_cmd(make_cmd(F_EXEC, 1'($urandom_range(1)), 0, 0, 0, 0));
        drain_results();
    endtask

    // random traffic under one idle setting, kept mostly small
    task automatic test_random(int n, int idle_pct);
        t_in c;
        send_idle_pct = idle_pct;
        for (int i = 0; i < n; i++) begin
            c = rand_cmd();
            if (c.func == F_PRINT && table_q.size() > 12 && $urandom_range(3) != 0)
                c.func = F_NEXT;
            if (c.func == F_ADD && table_q.size() > 10 && $urandom_range(2) != 0)
                c.func = F_EXEC;
            send_cmd(c);
            // hold off once per phase until all results are in
            if (i == n / 2) while (pending_results.size() != 0) @(posedge i_clk);
        end
        drain_results();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(90, 28);
        test_random(90, 64);
        test_random(90, 0);
        if (errors == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/dkpq_pkg.sv
rtl/core/dkpq_cell.sv
rtl/core/dual_key_process_queue.sv
verif/dual_key_process_queue_tb.sv
